@@ sv/vdgp_pkg.sv @@
package vdgp_pkg;

    localparam int IMAGE_ROWS_DEF = 512;
    localparam int DISP_BINS      = 256;
    localparam int DISP_W         = $clog2(DISP_BINS);
    localparam int ROW_IN_W       = 9;
    localparam int CNT_W          = 8;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 1;

    localparam logic [DISP_W-1:0] DISP_LOW     = DISP_W'(7);
    localparam logic [DISP_W-1:0] DISP_HIGH    = DISP_W'(252);
    localparam logic [CNT_W-1:0]  BIN_MAX      = CNT_W'(255);
    localparam logic [CNT_W-1:0]  THRESH_RESET = CNT_W'(50);

    localparam logic [CFG_IDX_W-1:0] REG_VANISHING_ROW   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESHOLD = CFG_IDX_W'(1);

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // request handed from the front end to the update stage
    typedef struct packed {
        logic valid;
        logic is_read;
        logic bin_hit;
    } bin_req_t;

endpackage

@@ sv/vdgp_hist_mem.sv @@
module vdgp_hist_mem #(
    parameter int ADDR_W = 17,
    parameter int DEPTH  = 131072
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [vdgp_pkg::CNT_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [vdgp_pkg::CNT_W-1:0] wr_data
);

    logic [vdgp_pkg::CNT_W-1:0] mem [DEPTH];
    logic [vdgp_pkg::CNT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/vdgp_bin_update.sv @@
module vdgp_bin_update #(
    parameter int ADDR_W = 17
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vdgp_pkg::bin_req_t         req,
    input  logic [ADDR_W-1:0]          req_addr,
    input  logic [vdgp_pkg::CNT_W-1:0] rd_data,
    input  logic [vdgp_pkg::CNT_W-1:0] noise_threshold,
    input  logic                       out_stall,
    output logic                       hold,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output logic [vdgp_pkg::CNT_W-1:0] wr_data,
    output logic                       out_valid,
    output logic [vdgp_pkg::CNT_W-1:0] bin_count,
    output logic                       is_ground_point
);

    vdgp_pkg::bin_req_t         s1_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       last_wr_valid_reg;
    logic [ADDR_W-1:0]          last_wr_addr_reg;
    logic [vdgp_pkg::CNT_W-1:0] last_wr_data_reg;
    logic                       out_valid_reg;
    logic [vdgp_pkg::CNT_W-1:0] bin_count_reg;
    logic                       ground_reg;

    logic                       advance;
    logic [vdgp_pkg::CNT_W-1:0] cur_count;
    logic [vdgp_pkg::CNT_W-1:0] new_count;
    logic [vdgp_pkg::CNT_W-1:0] result;

    // a read item waits here while the output register is full and stalled
    assign hold    = s1_reg.valid & s1_reg.is_read & out_valid_reg & out_stall;
    assign advance = s1_reg.valid & ~hold;

    always_comb
    begin
        // the memory read misses a write made on the same edge, so take it from here
        if (last_wr_valid_reg && (last_wr_addr_reg == s1_addr_reg))
        begin
            cur_count = last_wr_data_reg;
        end
        else
        begin
            cur_count = rd_data;
        end

        if (s1_reg.is_read)
        begin
            new_count = '0;
        end
        else if (cur_count == vdgp_pkg::BIN_MAX)
        begin
            new_count = cur_count;
        end
        else
        begin
            new_count = cur_count + vdgp_pkg::CNT_W'(1);
        end

        if (s1_reg.bin_hit && (cur_count > noise_threshold))
        begin
            result = cur_count;
        end
        else
        begin
            result = '0;
        end
    end

    assign wr_en   = advance & s1_reg.bin_hit;
    assign wr_addr = s1_addr_reg;
    assign wr_data = new_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg            <= '0;
            last_wr_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (!hold)
            begin
                s1_reg <= req;
            end
            if (wr_en)
            begin
                last_wr_valid_reg <= 1'b1;
            end
            if (advance && s1_reg.is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            s1_addr_reg <= req_addr;
        end
        if (wr_en)
        begin
            last_wr_addr_reg <= s1_addr_reg;
            last_wr_data_reg <= new_count;
        end
        if (advance && s1_reg.is_read)
        begin
            bin_count_reg <= result;
            ground_reg    <= (result != '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign bin_count       = bin_count_reg;
    assign is_ground_point = ground_reg;

endmodule

@@ sv/v_disparity_ground_points_unit.sv @@
// channel  direction  handshake            payload
// in       input      in_valid / in_stall   mode, row, disparity
// out      output     out_valid / out_stall bin_count, is_ground_point
// cfg      input      cfg_we                cfg_index, cfg_data
//
// one item per clock unless in_stall; read results pass s1 and output registers
// throughput is set by the single read-modify-write pass through the histogram ram
// after reset a clearing pass zeroes all IMAGE_ROWS * 256 ram entries (131072 by
// default), and in_stall stays high until it is done
// a read item waits in the update stage while out_stall holds a pending result
module v_disparity_ground_points_unit #(
    parameter int IMAGE_ROWS = vdgp_pkg::IMAGE_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [vdgp_pkg::ROW_IN_W-1:0]   row,
    input  logic [vdgp_pkg::DISP_W-1:0]     disparity,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [vdgp_pkg::CNT_W-1:0]      bin_count,
    output logic                            is_ground_point,
    input  logic                            cfg_we,
    input  logic [vdgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vdgp_pkg::CFG_W-1:0]      cfg_data
);

    localparam int ROW_W  = $clog2(IMAGE_ROWS);
    localparam int ADDR_W = ROW_W + vdgp_pkg::DISP_W;
    localparam int DEPTH  = IMAGE_ROWS * vdgp_pkg::DISP_BINS;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [vdgp_pkg::ROW_IN_W-1:0] vanishing_row_reg;
    logic [vdgp_pkg::CNT_W-1:0]    noise_threshold_reg;
    logic                          clear_reg;
    logic [ADDR_W-1:0]             clr_addr_reg;

    logic                          in_accept;
    logic                          row_ok;
    logic                          acc_ok;
    logic [31:0]                   row_ext;
    logic [ADDR_W-1:0]             in_addr;
    vdgp_pkg::bin_req_t            req;

    logic                          hold;
    logic                          upd_we;
    logic [ADDR_W-1:0]             upd_addr;
    logic [vdgp_pkg::CNT_W-1:0]    upd_data;
    logic [vdgp_pkg::CNT_W-1:0]    rd_data;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [vdgp_pkg::CNT_W-1:0]    mem_wdata;

    assign in_stall  = clear_reg | hold;
    assign in_accept = in_valid & ~in_stall;

    assign row_ext = 32'(row);
    assign row_ok  = (row_ext < 32'(IMAGE_ROWS));
    assign in_addr = {row_ext[ROW_W-1:0], disparity};
    assign acc_ok  = row_ok && (row >= vanishing_row_reg)
                     && (disparity >= vdgp_pkg::DISP_LOW)
                     && (disparity <= vdgp_pkg::DISP_HIGH);

    always_comb
    begin
        req.valid   = in_accept;
        req.is_read = (mode == vdgp_pkg::MODE_READ);
        req.bin_hit = (mode == vdgp_pkg::MODE_READ) ? row_ok : acc_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vanishing_row_reg   <= '0;
            noise_threshold_reg <= vdgp_pkg::THRESH_RESET;
            clear_reg           <= 1'b1;
            clr_addr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vdgp_pkg::REG_VANISHING_ROW:
                    begin
                        vanishing_row_reg <= cfg_data;
                    end
                    vdgp_pkg::REG_NOISE_THRESHOLD:
                    begin
                        noise_threshold_reg <= cfg_data[vdgp_pkg::CNT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (clear_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clear_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
            end
        end
    end

    // the clearing pass owns the write port until it finishes
    assign mem_we    = clear_reg | upd_we;
    assign mem_waddr = clear_reg ? clr_addr_reg : upd_addr;
    assign mem_wdata = clear_reg ? '0 : upd_data;

    vdgp_hist_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_accept & req.bin_hit),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    vdgp_bin_update #(
        .ADDR_W (ADDR_W)
    ) u_update (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .req_addr        (in_addr),
        .rd_data         (rd_data),
        .noise_threshold (noise_threshold_reg),
        .out_stall       (out_stall),
        .hold            (hold),
        .wr_en           (upd_we),
        .wr_addr         (upd_addr),
        .wr_data         (upd_data),
        .out_valid       (out_valid),
        .bin_count       (bin_count),
        .is_ground_point (is_ground_point)
    );

    a_flag_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_ground_point == (bin_count != '0)))
        else $error("ground flag disagrees with bin count");

    a_count_above_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (bin_count != '0)) |-> (bin_count > noise_threshold_reg))
        else $error("nonzero bin count not above noise threshold");

    a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !upd_we)
        else $error("bin update during clearing pass");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (clear_reg && $past(clear_reg) && !out_stall) |=> !out_valid)
        else $error("transaction produced during clearing pass");

endmodule
